[rtl/core/eapp_pkg.sv]
package eapp_pkg;

    localparam int COUNT_BITS      = 24;
    localparam int ANGLE_FRAC_BITS = 8;

    localparam int KEEP_W      = 16;
    localparam int GAIN_W      = 16;
    localparam int LIMIT_W     = 20;
    localparam int DLIM_W      = 8;
    localparam int OUT_ANGLE_W = 17;
    localparam int DUTY_W      = 8;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;

    localparam int HALF_TURN   = 180 << ANGLE_FRAC_BITS;
    localparam int FULL_TURN   = 360 << ANGLE_FRAC_BITS;
    localparam int FULL_W      = $clog2(FULL_TURN);
    localparam int TARGET_SPAN = (1 << (OUT_ANGLE_W - 1)) + 2 * HALF_TURN + 1;
    localparam int SPAN_W      = $clog2(TARGET_SPAN);

    localparam int FA_W  = COUNT_BITS + 16 - ANGLE_FRAC_BITS;
    localparam int E_W   = (ANGLE_FRAC_BITS + 9 > OUT_ANGLE_W) ? ANGLE_FRAC_BITS + 9
                                                               : OUT_ANGLE_W;
    localparam int I_W   = LIMIT_W + 1;
    localparam int WR_W  = ((FA_W > E_W + 1) ? FA_W : E_W + 1) + 1;
    localparam int MA_W0 = (I_W > E_W + 1) ? I_W : E_W + 1;
    localparam int MA_W  = (FA_W > MA_W0) ? FA_W : MA_W0;
    localparam int MB_W  = KEEP_W + 2;
    localparam int MP_W  = MA_W + MB_W;
    localparam int PW_W  = ((LIMIT_W > E_W) ? LIMIT_W : E_W) + GAIN_W + 3;
    localparam int ACC_W0 = (FA_W + 18 > PW_W) ? FA_W + 18 : PW_W;
    localparam int ACC_W = (ACC_W0 > MP_W) ? ACC_W0 : MP_W;

    localparam int DRIVE_SHIFT = 12 + ANGLE_FRAC_BITS;
    localparam int ANGLE_SHIFT = 16 - ANGLE_FRAC_BITS;
    localparam int KEEP_ONE    = 1 << KEEP_W;
    localparam int ROUND_HALF  = 1 << (KEEP_W - 1);

    localparam int WRAP_TOP_A = (FA_W > FULL_W) ? FA_W - FULL_W : 0;
    localparam int WRAP_TOP_E = (SPAN_W > FULL_W) ? SPAN_W - FULL_W : 0;
    localparam int WSH_W      = (WRAP_TOP_A > 0) ? $clog2(WRAP_TOP_A + 1) : 1;

    localparam int PC_W      = 5;
    localparam int LAST_STEP = 20;

    localparam logic [OP_W-1:0] OP_ENCODER = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
    localparam logic [OP_W-1:0] OP_ZERO    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEG_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANG_KEEP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ERR_KEEP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DRV_LIMIT = 3'd7;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_CNT_DPC,
        MUL_FA_KA,
        MUL_RAW_NKA,
        MUL_FE_KE,
        MUL_ERR_NKE,
        MUL_P,
        MUL_I,
        MUL_D
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD_RND,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_RAW,
        ACT_FANGLE,
        ACT_WLOAD_A,
        ACT_WSTEP,
        ACT_SHAFT,
        ACT_WLOAD_E,
        ACT_ERR,
        ACT_FERR,
        ACT_INTEG,
        ACT_PRIOR,
        ACT_DRIVE
    } t_act;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_WAIT_WRAP,
        SEQ_DONE
    } t_seq;

    typedef struct packed {
        t_mul_sel mul;
        t_acc_op  acc;
        t_act     act;
        t_seq     seq;
    } t_uword;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword uw;
        uw = '{mul: MUL_NONE, acc: ACC_HOLD, act: ACT_NONE, seq: SEQ_NEXT};
        unique case (pc)
            5'd0:  uw.mul = MUL_CNT_DPC;
            5'd1:  uw.act = ACT_RAW;
            5'd2:  uw.mul = MUL_FA_KA;
            5'd3: begin
                uw.acc = ACC_LOAD_RND;
                uw.mul = MUL_RAW_NKA;
            end
            5'd4:  uw.acc = ACC_ADD;
            5'd5:  uw.act = ACT_FANGLE;
            5'd6:  uw.act = ACT_WLOAD_A;
            5'd7: begin
                uw.act = ACT_WSTEP;
                uw.seq = SEQ_WAIT_WRAP;
            end
            5'd8:  uw.act = ACT_SHAFT;
            5'd9:  uw.act = ACT_WLOAD_E;
            5'd10: begin
                uw.act = ACT_WSTEP;
                uw.seq = SEQ_WAIT_WRAP;
            end
            5'd11: uw.act = ACT_ERR;
            5'd12: uw.mul = MUL_FE_KE;
            5'd13: begin
                uw.acc = ACC_LOAD_RND;
                uw.mul = MUL_ERR_NKE;
            end
            5'd14: uw.acc = ACC_ADD;
            5'd15: uw.act = ACT_FERR;
            5'd16: begin
                uw.act = ACT_INTEG;
                uw.mul = MUL_P;
            end
            5'd17: begin
                uw.acc = ACC_LOAD;
                uw.mul = MUL_I;
            end
            5'd18: begin
                uw.acc = ACC_ADD;
                uw.mul = MUL_D;
                uw.act = ACT_PRIOR;
            end
            5'd19: uw.acc = ACC_ADD;
            5'd20: begin
                uw.act = ACT_DRIVE;
                uw.seq = SEQ_DONE;
            end
            default: uw.seq = SEQ_DONE;
        endcase
        return uw;
    endfunction

endpackage

[rtl/core/encoder_angle_pid_position_loop.sv]
// Position regulator for a brushed motor with a quadrature encoder decoder.
// Requests arrive on the input channel (i_in_valid / o_in_ready) with an op code.
// An encoder sample or a zero-position request acts in the cycle it is taken and
// gives no result; these are accepted even while a result waits on the output.
// A control tick starts a microcoded sequence over one shared multiplier, one
// accumulator and a shift-and-subtract wrap unit. The wrap loops set the
// length of a tick, and its result appears on the output channel
// (o_out_valid / i_out_ready) in the cycle after its final step.
// While a tick runs, o_in_ready is low; the next request is taken in the cycle
// after the result has been loaded into the output register.
// If the receiver stalls, the result is held in the output register and a
// further tick waits at its final step until the register is free.
// The gains, scale, filter factors and limits are written through the plain
// configuration port, by the user only while idle; the block does not enforce it.
// Reset clears the count, the filters, the integral and the sequencer, and
// loads the configuration registers with their default values.
module encoder_angle_pid_position_loop
    import eapp_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [OP_W-1:0]               i_op,
    input  logic                          i_enc_a,
    input  logic                          i_enc_b,
    input  logic signed [OUT_ANGLE_W-1:0] i_target_angle,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [DUTY_W-1:0]             o_duty,
    output logic                          o_forward,
    output logic signed [OUT_ANGLE_W-1:0] o_shaft_angle,
    output logic signed [OUT_ANGLE_W-1:0] o_smoothed_error,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    typedef enum logic [1:0] {
        WM_IN,
        WM_POS,
        WM_NEG
    } t_wmode;

    localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
    localparam logic signed [WR_W-1:0]  W_HALF  = WR_W'(HALF_TURN);
    localparam logic signed [WR_W-1:0]  W_FULL  = WR_W'(FULL_TURN);
    localparam logic signed [E_W-1:0]   E_HALF  = E_W'(HALF_TURN);
    localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(ROUND_HALF);
    localparam logic [MB_W-1:0]         MB_ONE  = MB_W'(KEEP_ONE);

    logic [GAIN_W-1:0]  r_gain_p;
    logic [GAIN_W-1:0]  r_gain_i;
    logic [GAIN_W-1:0]  r_gain_d;
    logic [KEEP_W-1:0]  r_deg_count;
    logic [KEEP_W-1:0]  r_ang_keep;
    logic [KEEP_W-1:0]  r_err_keep;
    logic [LIMIT_W-1:0] r_int_limit;
    logic [DLIM_W-1:0]  r_drv_limit;

    logic signed [COUNT_BITS-1:0] r_count;
    logic                         r_prev_a;
    logic signed [FA_W-1:0]       r_fangle;
    logic signed [E_W-1:0]        r_ferr;
    logic signed [I_W-1:0]        r_integ;
    logic signed [E_W-1:0]        r_prior;

    logic                  r_busy;
    logic [PC_W-1:0]       r_pc;
    logic [WSH_W-1:0]      r_wsh;
    logic                  r_out_valid;

    logic signed [OUT_ANGLE_W-1:0] r_target;
    logic signed [MP_W-1:0]        r_prod;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [FA_W-1:0]        r_raw;
    logic signed [WR_W-1:0]        r_wv;
    t_wmode                        r_wmode;
    logic signed [E_W-1:0]         r_shaft;
    logic signed [E_W-1:0]         r_err;
    logic [DUTY_W-1:0]             r_duty;
    logic                          r_forward;
    logic signed [OUT_ANGLE_W-1:0] r_out_shaft;
    logic signed [OUT_ANGLE_W-1:0] r_out_err;

    t_uword                  uw;
    logic                    in_acc;
    logic                    out_free;
    logic                    step_go;
    logic signed [MA_W-1:0]  ma;
    logic signed [MB_W-1:0]  mb;
    logic signed [WR_W-1:0]  wx;
    logic signed [WR_W-1:0]  wsub;
    logic signed [WR_W-1:0]  wres;
    logic signed [I_W:0]     isum;
    logic signed [I_W:0]     ilim;
    logic signed [I_W:0]     iclamp;
    logic signed [ACC_W-1:0] dlim;
    logic signed [ACC_W-1:0] dclamp;
    logic signed [ACC_W-1:0] dmag;

    assign uw       = ucode(r_pc);
    assign in_acc   = i_in_valid && !r_busy;
    assign out_free = !r_out_valid || i_out_ready;
    assign step_go  = r_busy && ((uw.seq != SEQ_DONE) || out_free);

    assign o_in_ready       = !r_busy;
    assign o_out_valid      = r_out_valid;
    assign o_duty           = r_duty;
    assign o_forward        = r_forward;
    assign o_shaft_angle    = r_out_shaft;
    assign o_smoothed_error = r_out_err;

    always_comb begin
        ma = '0;
        mb = '0;
        unique case (uw.mul)
            MUL_NONE: begin
                ma = '0;
                mb = '0;
            end
            MUL_CNT_DPC: begin
                ma = MA_W'(r_count);
                mb = MB_W'(r_deg_count);
            end
            MUL_FA_KA: begin
                ma = MA_W'(r_fangle);
                mb = MB_W'(r_ang_keep);
            end
            MUL_RAW_NKA: begin
                ma = MA_W'(r_raw);
                mb = MB_ONE - MB_W'(r_ang_keep);
            end
            MUL_FE_KE: begin
                ma = MA_W'(r_ferr);
                mb = MB_W'(r_err_keep);
            end
            MUL_ERR_NKE: begin
                ma = MA_W'(r_err);
                mb = MB_ONE - MB_W'(r_err_keep);
            end
            MUL_P: begin
                ma = MA_W'(r_ferr);
                mb = MB_W'(r_gain_p);
            end
            MUL_I: begin
                ma = MA_W'(r_integ);
                mb = MB_W'(r_gain_i);
            end
            MUL_D: begin
                ma = MA_W'(r_ferr) - MA_W'(r_prior);
                mb = MB_W'(r_gain_d);
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_comb begin
        if (uw.act == ACT_WLOAD_A) begin
            wx = WR_W'(r_fangle);
        end else begin
            wx = WR_W'(r_target) - WR_W'(r_shaft);
        end
        wsub = r_wv - (W_FULL <<< r_wsh);
        unique case (r_wmode)
            WM_POS:  wres = r_wv - W_HALF + WR_W'(1);
            WM_NEG:  wres = W_HALF - WR_W'(1) - r_wv;
            default: wres = r_wv;
        endcase
    end

    always_comb begin
        isum = (I_W+1)'(r_integ) + (I_W+1)'(r_ferr);
        ilim = (I_W+1)'(r_int_limit);
        if (isum > ilim) begin
            iclamp = ilim;
        end else if (isum < -ilim) begin
            iclamp = -ilim;
        end else begin
            iclamp = isum;
        end
        dlim = ACC_W'(r_drv_limit) <<< DRIVE_SHIFT;
        if (r_acc > dlim) begin
            dclamp = dlim;
        end else if (r_acc < -dlim) begin
            dclamp = -dlim;
        end else begin
            dclamp = r_acc;
        end
        dmag = (dclamp < 0) ? -dclamp : dclamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= GAIN_W'(4915);
            r_gain_i    <= GAIN_W'(123);
            r_gain_d    <= GAIN_W'(205);
            r_deg_count <= KEEP_W'(23831);
            r_ang_keep  <= KEEP_W'(55706);
            r_err_keep  <= KEEP_W'(39322);
            r_int_limit <= LIMIT_W'(76800);
            r_drv_limit <= DLIM_W'(255);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GAIN_P:    r_gain_p    <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I:    r_gain_i    <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D:    r_gain_d    <= i_cfg_data[GAIN_W-1:0];
                REG_DEG_COUNT: r_deg_count <= i_cfg_data[KEEP_W-1:0];
                REG_ANG_KEEP:  r_ang_keep  <= i_cfg_data[KEEP_W-1:0];
                REG_ERR_KEEP:  r_err_keep  <= i_cfg_data[KEEP_W-1:0];
                REG_INT_LIMIT: r_int_limit <= i_cfg_data[LIMIT_W-1:0];
                REG_DRV_LIMIT: r_drv_limit <= i_cfg_data[DLIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_prev_a    <= 1'b0;
            r_fangle    <= '0;
            r_ferr      <= '0;
            r_integ     <= '0;
            r_prior     <= '0;
            r_busy      <= 1'b0;
            r_pc        <= '0;
            r_wsh       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_busy && uw.seq == SEQ_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (in_acc) begin
                priority if (i_op == OP_ENCODER) begin
                    if (i_enc_a != r_prev_a) begin
                        if (i_enc_a == i_enc_b) begin
                            if (r_count != CNT_MIN) begin
                                r_count <= r_count - COUNT_BITS'(1);
                            end
                        end else begin
                            if (r_count != CNT_MAX) begin
                                r_count <= r_count + COUNT_BITS'(1);
                            end
                        end
                        r_prev_a <= i_enc_a;
                    end
                end else if (i_op == OP_ZERO) begin
                    r_count  <= '0;
                    r_fangle <= '0;
                end else if (i_op == OP_TICK) begin
                    r_busy <= 1'b1;
                    r_pc   <= '0;
                end else begin
                end
            end

            if (step_go) begin
                unique case (uw.seq)
                    SEQ_WAIT_WRAP: begin
                        if (r_wsh == '0) begin
                            r_pc <= r_pc + PC_W'(1);
                        end
                    end
                    SEQ_DONE: r_busy <= 1'b0;
                    default:  r_pc <= r_pc + PC_W'(1);
                endcase

                unique case (uw.act)
                    ACT_FANGLE:  r_fangle <= FA_W'(r_acc >>> KEEP_W);
                    ACT_WLOAD_A: r_wsh <= WSH_W'(WRAP_TOP_A);
                    ACT_WLOAD_E: r_wsh <= WSH_W'(WRAP_TOP_E);
                    ACT_WSTEP: begin
                        if (r_wsh != '0) begin
                            r_wsh <= r_wsh - WSH_W'(1);
                        end
                    end
                    ACT_FERR:  r_ferr <= E_W'(r_acc >>> KEEP_W);
                    ACT_INTEG: r_integ <= I_W'(iclamp);
                    ACT_PRIOR: r_prior <= r_ferr;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_op == OP_TICK) begin
            r_target <= i_target_angle;
        end
        if (step_go) begin
            if (uw.mul != MUL_NONE) begin
                r_prod <= MP_W'(ma) * MP_W'(mb);
            end
            unique case (uw.acc)
                ACC_LOAD_RND: r_acc <= ACC_W'(r_prod) + ACC_RND;
                ACC_LOAD:     r_acc <= ACC_W'(r_prod);
                ACC_ADD:      r_acc <= r_acc + ACC_W'(r_prod);
                default: ;
            endcase
            unique case (uw.act)
                ACT_RAW: r_raw <= FA_W'(r_prod >>> ANGLE_SHIFT);
                ACT_WLOAD_A, ACT_WLOAD_E: begin
                    if (wx > W_HALF) begin
                        r_wmode <= WM_POS;
                        r_wv    <= wx - W_HALF - WR_W'(1);
                    end else if (wx < -W_HALF) begin
                        r_wmode <= WM_NEG;
                        r_wv    <= -W_HALF - WR_W'(1) - wx;
                    end else begin
                        r_wmode <= WM_IN;
                        r_wv    <= wx;
                    end
                end
                ACT_WSTEP: begin
                    if (r_wmode != WM_IN && wsub >= 0) begin
                        r_wv <= wsub;
                    end
                end
                ACT_SHAFT: r_shaft <= E_W'(wres);
                ACT_ERR:   r_err <= E_W'(wres);
                ACT_DRIVE: begin
                    r_duty      <= DUTY_W'(dmag >>> DRIVE_SHIFT);
                    r_forward   <= (dclamp > 0);
                    r_out_shaft <= OUT_ANGLE_W'(r_shaft);
                    r_out_err   <= OUT_ANGLE_W'(r_ferr);
                end
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_result_from_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy))
        else $error("Result appeared without a running tick.");

    a_pc_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc <= PC_W'(LAST_STEP)))
        else $error("Step counter ran past the end of the program.");

    a_shaft_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_shaft >= -E_HALF && r_shaft <= E_HALF))
        else $error("Shaft angle left the half-turn range.");

    a_error_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ferr >= -E_HALF && r_ferr <= E_HALF))
        else $error("Filtered error left the half-turn range.");
`endif

endmodule
